FILE: rtl/rsmr_pkg.sv
package rsmr_pkg;

    // operand and result widths
    localparam int OPERAND_WIDTH = 16;
    localparam int NUM_W         = 2 * OPERAND_WIDTH;
    localparam int MAG_W         = 2 * OPERAND_WIDTH - 1;
    localparam int DEN_W         = 2 * OPERAND_WIDTH - 2;
    localparam int K_W           = $clog2(DEN_W + 1);
    localparam int DIV_CNT_W     = $clog2(MAG_W + 1);

    // operation codes
    localparam logic [1:0] OP_SUB    = 2'd0;
    localparam logic [1:0] OP_MUL    = 2'd1;
    localparam logic [1:0] OP_REDUCE = 2'd2;

    // shared multiplier product select
    localparam logic [1:0] MS_CROSS_L = 2'd0;
    localparam logic [1:0] MS_CROSS_R = 2'd1;
    localparam logic [1:0] MS_DEN     = 2'd2;

    // divider dividend select
    localparam logic DS_NUM = 1'b0;
    localparam logic DS_DEN = 1'b1;

    typedef struct packed {
        logic [1:0]                     operation;
        logic signed [OPERAND_WIDTH-1:0] left_numerator;
        logic [OPERAND_WIDTH-2:0]       left_denominator;
        logic signed [OPERAND_WIDTH-1:0] right_numerator;
        logic [OPERAND_WIDTH-2:0]       right_denominator;
    } operand_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] result_numerator;
        logic [DEN_W-1:0]        result_denominator;
        logic                    bad_denominator;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       form;
        logic       gcd_step;
        logic       div_start;
        logic       div_sel;
        logic       save_num;
        logic       save_den;
        logic       load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic special;
        logic gcd_done;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/rsmr_div.sv
module rsmr_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rsmr_pkg::MAG_W-1:0]     dividend,
    input  logic [rsmr_pkg::MAG_W-1:0]     divisor,
    output logic                           done,
    output logic [rsmr_pkg::MAG_W-1:0]     quotient
);

    localparam int W  = rsmr_pkg::MAG_W;
    localparam int CW = rsmr_pkg::DIV_CNT_W;

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    trial;

    // one restoring step per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/rsmr_dpath.sv
module rsmr_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  rsmr_pkg::operand_t operand,
    input  rsmr_pkg::cmd_t     cmd,
    output rsmr_pkg::sts_t     sts,
    input  logic               result_ready,
    output logic               result_valid,
    output rsmr_pkg::result_t  result
);

    localparam int W     = rsmr_pkg::OPERAND_WIDTH;
    localparam int NUM_W = rsmr_pkg::NUM_W;
    localparam int MAG_W = rsmr_pkg::MAG_W;
    localparam int DEN_W = rsmr_pkg::DEN_W;
    localparam int K_W   = rsmr_pkg::K_W;

    // captured request
    logic [1:0]          op_reg;
    logic signed [W-1:0] ln_reg, rn_reg;
    logic [W-2:0]        ld_reg, rd_reg;

    // products and formed fraction
    logic signed [NUM_W-1:0] p0_reg, p1_reg, pd_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    neg_reg, bad_reg, zero_reg;

    // gcd state
    logic [MAG_W-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [MAG_W-1:0] gcd_val;

    // quotients and output
    logic [MAG_W-1:0]  qn_reg;
    logic [DEN_W-1:0]  qd_reg;
    rsmr_pkg::result_t result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    logic                    pair_op, sub_op, mul_op;
    logic signed [W-1:0]     ld_s, rd_s, one_s;
    logic signed [W-1:0]     mul_a, mul_b;
    logic signed [NUM_W-1:0] prod;
    logic signed [NUM_W-1:0] diff;
    logic [NUM_W-1:0]        diff_abs;
    logic                    bad_now;
    logic [MAG_W-1:0]        div_dividend;
    logic [MAG_W-1:0]        div_quotient;
    logic                    div_done;
    logic [NUM_W-1:0]        qn_ext;

    assign sub_op  = (op_reg == rsmr_pkg::OP_SUB);
    assign mul_op  = (op_reg == rsmr_pkg::OP_MUL);
    assign pair_op = sub_op || mul_op;
    assign ld_s    = $signed({1'b0, ld_reg});
    assign rd_s    = $signed({1'b0, rd_reg});
    assign one_s   = W'(1);

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            rsmr_pkg::MS_CROSS_L:
            begin
                mul_a = ln_reg;
                mul_b = sub_op ? rd_s : (mul_op ? rn_reg : one_s);
            end
            rsmr_pkg::MS_CROSS_R:
            begin
                mul_a = rn_reg;
                mul_b = sub_op ? ld_s : '0;
            end
            rsmr_pkg::MS_DEN:
            begin
                mul_a = ld_s;
                mul_b = pair_op ? rd_s : one_s;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // fraction forming
    assign diff     = p0_reg - p1_reg;
    assign diff_abs = diff[NUM_W-1] ? (NUM_W'(0) - diff) : diff;
    assign bad_now  = (ld_reg == '0) || (pair_op && (rd_reg == '0));

    // binary gcd step, operands both nonzero while running
    always_comb
    begin
        ga_next = ga_reg;
        gb_next = gb_reg;
        k_next  = k_reg;
        if (cmd.form)
        begin
            ga_next = diff_abs[MAG_W-1:0];
            gb_next = {{(MAG_W-DEN_W){1'b0}}, pd_reg[DEN_W-1:0]};
            k_next  = '0;
        end
        else if (cmd.gcd_step)
        begin
            case ({ga_reg[0], gb_reg[0]})
                2'b00:
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    k_next  = k_reg + 1'b1;
                end
                2'b01: ga_next = ga_reg >> 1;
                2'b10: gb_next = gb_reg >> 1;
                default:
                begin
                    if (ga_reg > gb_reg)
                    begin
                        ga_next = (ga_reg - gb_reg) >> 1;
                    end
                    else
                    begin
                        gb_next = (gb_reg - ga_reg) >> 1;
                    end
                end
            endcase
        end
    end

    assign gcd_val = ga_reg << k_reg;

    // shared divider for both quotients
    assign div_dividend = (cmd.div_sel == rsmr_pkg::DS_DEN)
                        ? {{(MAG_W-DEN_W){1'b0}}, den_reg} : mag_reg;

    rsmr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (gcd_val),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // result assembly
    assign qn_ext = {1'b0, qn_reg};
    always_comb
    begin
        if (bad_reg)
        begin
            result_next.result_numerator   = '0;
            result_next.result_denominator = '0;
            result_next.bad_denominator    = 1'b1;
        end
        else if (zero_reg)
        begin
            result_next.result_numerator   = '0;
            result_next.result_denominator = DEN_W'(1);
            result_next.bad_denominator    = 1'b0;
        end
        else
        begin
            result_next.result_numerator   = neg_reg ? $signed(NUM_W'(0) - qn_ext)
                                                     : $signed(qn_ext);
            result_next.result_denominator = qd_reg;
            result_next.bad_denominator    = 1'b0;
        end
    end

    // output valid
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.load_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= operand.operation;
            ln_reg <= operand.left_numerator;
            ld_reg <= operand.left_denominator;
            rn_reg <= operand.right_numerator;
            rd_reg <= operand.right_denominator;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                rsmr_pkg::MS_CROSS_L: p0_reg <= prod;
                rsmr_pkg::MS_CROSS_R: p1_reg <= prod;
                rsmr_pkg::MS_DEN:     pd_reg <= prod;
                default:              pd_reg <= pd_reg;
            endcase
        end
        if (cmd.form)
        begin
            mag_reg  <= diff_abs[MAG_W-1:0];
            den_reg  <= pd_reg[DEN_W-1:0];
            neg_reg  <= diff[NUM_W-1];
            bad_reg  <= bad_now;
            zero_reg <= (diff == '0);
        end
        ga_reg <= ga_next;
        gb_reg <= gb_next;
        k_reg  <= k_next;
        if (cmd.save_num)
        begin
            qn_reg <= div_quotient;
        end
        if (cmd.save_den)
        begin
            qd_reg <= div_quotient[DEN_W-1:0];
        end
        if (cmd.load_out)
        begin
            result_reg <= result_next;
        end
    end

    // status back to the controller
    assign sts.special  = bad_reg || zero_reg;
    assign sts.gcd_done = (ga_reg == gb_reg);
    assign sts.div_done = div_done;
    assign sts.out_free = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/rsmr_ctrl.sv
module rsmr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           operand_valid,
    output logic           operand_ready,
    input  rsmr_pkg::sts_t sts,
    output rsmr_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_P0    = 4'd1;
    localparam logic [3:0] S_P1    = 4'd2;
    localparam logic [3:0] S_P2    = 4'd3;
    localparam logic [3:0] S_FORM  = 4'd4;
    localparam logic [3:0] S_GCD   = 4'd5;
    localparam logic [3:0] S_DIVN  = 4'd6;
    localparam logic [3:0] S_WAITN = 4'd7;
    localparam logic [3:0] S_DIVD  = 4'd8;
    localparam logic [3:0] S_WAITD = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] state_reg, state_next;

    // sequencing of one request
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_sel   = rsmr_pkg::MS_CROSS_L;
        cmd.div_sel   = rsmr_pkg::DS_NUM;
        operand_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                operand_ready = 1'b1;
                if (operand_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_P0;
                end
            end
            S_P0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rsmr_pkg::MS_CROSS_L;
                state_next  = S_P1;
            end
            S_P1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rsmr_pkg::MS_CROSS_R;
                state_next  = S_P2;
            end
            S_P2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rsmr_pkg::MS_DEN;
                state_next  = S_FORM;
            end
            S_FORM:
            begin
                cmd.form   = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (sts.special)
                begin
                    state_next = S_FIN;
                end
                else if (sts.gcd_done)
                begin
                    state_next = S_DIVN;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = rsmr_pkg::DS_NUM;
                state_next    = S_WAITN;
            end
            S_WAITN:
            begin
                if (sts.div_done)
                begin
                    cmd.save_num = 1'b1;
                    state_next   = S_DIVD;
                end
            end
            S_DIVD:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = rsmr_pkg::DS_DEN;
                state_next    = S_WAITD;
            end
            S_WAITD:
            begin
                if (sts.div_done)
                begin
                    cmd.save_den = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/rational_sub_mul_reduce_unit.sv
// a zero numerator or bad denominator runs idle, P0, P1, P2, FORM and GCD, then goes to FIN;
// otherwise GCD runs the binary gcd loop, then the numerator and denominator divides, then FIN
// one request at a time; the time per request is set by the one-step-per-cycle gcd loop
// and the shared bit-serial divider
// reset: rst_n clears the controller, divider and output valid; nothing is pending after it
module rational_sub_mul_reduce_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               operand_valid,
    output logic               operand_ready,
    input  rsmr_pkg::operand_t operand,
    output logic               result_valid,
    input  logic               result_ready,
    output rsmr_pkg::result_t  result
);

    rsmr_pkg::cmd_t cmd;
    rsmr_pkg::sts_t sts;

    // sequencer
    rsmr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_ready (operand_ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    // arithmetic
    rsmr_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .operand      (operand),
        .cmd          (cmd),
        .sts          (sts),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: rtl/rsmr_checker.sv
module rsmr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               operand_valid,
    input logic               operand_ready,
    input logic               result_valid,
    input logic               result_ready,
    input rsmr_pkg::result_t  result
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        operand_valid && operand_ready |=> !operand_ready)
        else $error("second request taken while busy");

    // error result is all zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_denominator |->
            result.result_numerator == '0 && result.result_denominator == '0)
        else $error("error result not zeroed");

    // good result has positive denominator
    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.bad_denominator |-> result.result_denominator != '0)
        else $error("zero denominator without error");

    // zero numerator reduces to one
    a_zero_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.bad_denominator && result.result_numerator == '0 |->
            result.result_denominator == 30'd1)
        else $error("zero not reduced to 0/1");

endmodule

bind rational_sub_mul_reduce_unit rsmr_checker u_rsmr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .operand_valid (operand_valid),
    .operand_ready (operand_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
);

FILE: dv/rational_sub_mul_reduce_unit_tb.sv
module rational_sub_mul_reduce_unit_tb;

    // code 3 is not defined by the package, the block handles it like a reduce
    localparam logic [1:0] OP_UNDEF = 2'd3;

    localparam int LN_W = rsmr_pkg::OPERAND_WIDTH;
    localparam int LD_W = rsmr_pkg::OPERAND_WIDTH - 1;
    localparam int RN_W = rsmr_pkg::NUM_W;
    localparam int RD_W = rsmr_pkg::DEN_W;

    localparam int RANDOM_REQUESTS = 1600;
    localparam int HOLD_AFTER      = 400;
    localparam int LONG_HOLD       = 3000;
    localparam int DRAIN_CYCLES    = 300;
    localparam int LIMIT_CYCLES    = 1_500_000;

    typedef struct {
        rsmr_pkg::operand_t req;
        bit                 typed;
        rsmr_pkg::result_t  res;
    } row_t;

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               operand_valid = 1'b0;
    logic               operand_ready;
    rsmr_pkg::operand_t operand       = '0;
    logic               result_valid;
    logic               result_ready  = 1'b0;
    rsmr_pkg::result_t  result;

    rsmr_pkg::result_t pending_fractions[$];
    row_t              directed_rows[$];
    int                mismatch_count = 0;
    int                results_seen   = 0;

    rational_sub_mul_reduce_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_ready (operand_ready),
        .operand       (operand),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(2 * LIMIT_CYCLES);
        $display("** rational_sub_mul_reduce_unit: FAILED **");
        $finish;
    end

    // exact fraction result: difference or product, then divide out the gcd
    function automatic rsmr_pkg::result_t reduce_fraction(rsmr_pkg::operand_t req);
        longint            ln;
        longint            rn;
        longint            num;
        longint unsigned   ld;
        longint unsigned   rd;
        longint unsigned   den;
        longint unsigned   mag;
        longint unsigned   a;
        longint unsigned   b;
        longint unsigned   r;
        rsmr_pkg::result_t res;
        ln  = longint'($signed(req.left_numerator));
        rn  = longint'($signed(req.right_numerator));
        ld  = 64'(req.left_denominator);
        rd  = 64'(req.right_denominator);
        res = '0;
        if (req.operation == rsmr_pkg::OP_SUB || req.operation == rsmr_pkg::OP_MUL)
        begin
            if (ld == 0 || rd == 0)
            begin
                res.bad_denominator = 1'b1;
                return res;
            end
            if (req.operation == rsmr_pkg::OP_SUB)
                num = ln * longint'(rd) - rn * longint'(ld);
            else
                num = ln * rn;
            den = ld * rd;
        end
        else
        begin
            // reduce and the undefined code use the left fraction only
            if (ld == 0)
            begin
                res.bad_denominator = 1'b1;
                return res;
            end
            num = ln;
            den = ld;
        end
        if (num == 0)
        begin
            res.result_denominator = RD_W'(1);
            return res;
        end
        mag = (num < 0) ? longint'(-num) : longint'(num);
        a = mag;
        b = den;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        mag = mag / a;
        den = den / a;
        if (num < 0)
            mag = -mag;
        res.result_numerator   = mag[RN_W-1:0];
        res.result_denominator = den[RD_W-1:0];
        return res;
    endfunction

    // one directed row, with its result typed in when typed is set
    task automatic add_row(input logic [1:0] op, input int ln, input int ld, input int rn,
                           input int rd, input bit typed, input longint num, input int den,
                           input bit bad);
        row_t row;
        row.req.operation            = op;
        row.req.left_numerator       = ln[LN_W-1:0];
        row.req.left_denominator     = ld[LD_W-1:0];
        row.req.right_numerator      = rn[LN_W-1:0];
        row.req.right_denominator    = rd[LD_W-1:0];
        row.typed                    = typed;
        row.res.result_numerator     = num[RN_W-1:0];
        row.res.result_denominator   = den[RD_W-1:0];
        row.res.bad_denominator      = bad;
        directed_rows.push_back(row);
    endtask

    // random denominator: mostly valid, small, large, extreme or sharing a factor
    function automatic logic [LD_W-1:0] random_denominator(int factor);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        else if (pick <= 2)
            return $urandom_range(0, 1) ? 15'd32767 : 15'd1;
        else if (pick <= 8)
            return LD_W'($urandom_range(1, 32767));
        else if (pick <= 14)
            return LD_W'($urandom_range(1, 16));
        else
            return LD_W'(factor * $urandom_range(1, 200));
    endfunction

    // random numerator: zero, extremes, full range, small, or sharing a factor
    function automatic logic signed [LN_W-1:0] random_numerator(int factor);
        int pick;
        int val;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        else if (pick <= 2)
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        else if (pick <= 8)
            return LN_W'($urandom_range(0, 65535));
        else if (pick <= 13)
            return LN_W'($urandom_range(0, 32) - 16);
        else
        begin
            val = factor * $urandom_range(0, 200);
            return $urandom_range(0, 1) ? LN_W'(-val) : LN_W'(val);
        end
    endfunction

    function automatic rsmr_pkg::operand_t random_request();
        rsmr_pkg::operand_t req;
        int                 pick;
        int                 factor;
        pick   = $urandom_range(0, 15);
        factor = $urandom_range(1, 64);
        if (pick <= 5)
            req.operation = rsmr_pkg::OP_SUB;
        else if (pick <= 11)
            req.operation = rsmr_pkg::OP_MUL;
        else if (pick <= 14)
            req.operation = rsmr_pkg::OP_REDUCE;
        else
            req.operation = OP_UNDEF;
        req.left_numerator    = random_numerator(factor);
        req.left_denominator  = random_denominator(factor);
        req.right_numerator   = random_numerator(factor);
        req.right_denominator = random_denominator(factor);
        return req;
    endfunction

    // offer one request and hold it until accepted
    task automatic offer_request(input rsmr_pkg::operand_t req, input bit typed,
                                 input rsmr_pkg::result_t res);
        operand       <= req;
        operand_valid <= 1'b1;
        do
            @(posedge clk);
        while (!operand_ready);
        pending_fractions.push_back(typed ? res : reduce_fraction(req));
    endtask

    task automatic rest(input int cycles);
        operand_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // sender: reset, directed rows, then random bursts
    initial
    begin : sender
        int sent;
        int burst;
        int wait_cycles;
        rsmr_pkg::result_t none;
        none = '0;

        // zero numerator, bad denominators, and the undefined code
        add_row(rsmr_pkg::OP_REDUCE, 0, 5, 7, 3, 1, 0, 1, 0);
        add_row(rsmr_pkg::OP_SUB, 3, 0, 1, 2, 1, 0, 0, 1);
        add_row(rsmr_pkg::OP_MUL, 3, 4, 1, 0, 1, 0, 0, 1);
        add_row(rsmr_pkg::OP_SUB, 5, 0, -5, 0, 1, 0, 0, 1);
        add_row(rsmr_pkg::OP_SUB, 1, 7, 2, 0, 1, 0, 0, 1);
        add_row(rsmr_pkg::OP_REDUCE, 9, 0, 1, 1, 1, 0, 0, 1);
        add_row(rsmr_pkg::OP_REDUCE, 6, 4, -1, 0, 1, 3, 2, 0);
        add_row(OP_UNDEF, 4, 0, 1, 1, 1, 0, 0, 1);
        add_row(OP_UNDEF, 10, 4, 3, 0, 1, 5, 2, 0);
        add_row(OP_UNDEF, 0, 0, 1, 1, 1, 0, 0, 1);
        add_row(rsmr_pkg::OP_SUB, 1, 2, 2, 4, 1, 0, 1, 0);
        add_row(rsmr_pkg::OP_MUL, 0, 9, -32768, 32767, 1, 0, 1, 0);
        // extremes of the fields
        add_row(rsmr_pkg::OP_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1, 0);
        add_row(rsmr_pkg::OP_SUB, -32768, 1, 32767, 1, 1, -65535, 1, 0);
        add_row(rsmr_pkg::OP_MUL, 1, 32767, 1, 32767, 1, 1, 1073676289, 0);
        add_row(rsmr_pkg::OP_MUL, 32767, 32767, 32767, 1, 1, 32767, 1, 0);
        add_row(rsmr_pkg::OP_REDUCE, 32767, 32767, 0, 0, 1, 1, 1, 0);
        add_row(rsmr_pkg::OP_REDUCE, -32768, 2, 0, 1, 1, -16384, 1, 0);
        add_row(rsmr_pkg::OP_SUB, -32768, 32767, 32767, 32767, 0, 0, 0, 0);
        add_row(rsmr_pkg::OP_SUB, 32767, 32767, -32768, 32766, 0, 0, 0, 0);
        add_row(rsmr_pkg::OP_MUL, -32768, 32767, 32767, 32766, 0, 0, 0, 0);
        add_row(rsmr_pkg::OP_REDUCE, -32768, 32767, 0, 0, 0, 0, 0, 0);
        // ordinary reductions
        add_row(rsmr_pkg::OP_SUB, 1, 2, 1, 3, 1, 1, 6, 0);
        add_row(rsmr_pkg::OP_MUL, -3, 4, 2, 3, 1, -1, 2, 0);
        add_row(rsmr_pkg::OP_MUL, -1, 1, 1, 1, 1, -1, 1, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < RANDOM_REQUESTS; i++)
            begin
                offer_request(random_request(), 1'b0, none);
                sent++;
            end
            // every other stretch of 256 requests runs without gaps
            if (((sent / 256) % 2) == 0 && $urandom_range(0, 3) != 0)
            begin
                wait_cycles = $urandom_range(1, 20);
                rest(wait_cycles);
            end
        end
        operand_valid <= 1'b0;

        // drain, then watch for stray results
        while (pending_fractions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** rational_sub_mul_reduce_unit: PASSED **");
        else
            $display("** rational_sub_mul_reduce_unit: FAILED **");
        $finish;
    end

    // receiver: changing stall patterns, plus one long hold-off that backs up the block
    initial
    begin : receiver
        int mode;
        int span;
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span)
            begin
                @(posedge clk);
                if (!long_hold_done && results_seen >= HOLD_AFTER)
                begin
                    long_hold_done = 1'b1;
                    result_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom_range(0, 1));
                    2:       result_ready <= ($urandom_range(0, 3) == 0);
                    default: result_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // compare each accepted result with the oldest pending fraction
    always @(posedge clk)
    begin : check_results
        rsmr_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen <= results_seen + 1;
            if (pending_fractions.size() == 0)
            begin
                $error("result with no request pending: %0d/%0d bad %0b",
                       result.result_numerator, result.result_denominator,
                       result.bad_denominator);
                mismatch_count++;
            end
            else
            begin
                want = pending_fractions.pop_front();
                if (result.result_numerator !== want.result_numerator)
                begin
                    $error("result_numerator: expected %0d, actual %0d",
                           want.result_numerator, result.result_numerator);
                    mismatch_count++;
                end
                if (result.result_denominator !== want.result_denominator)
                begin
                    $error("result_denominator: expected %0d, actual %0d",
                           want.result_denominator, result.result_denominator);
                    mismatch_count++;
                end
                if (result.bad_denominator !== want.bad_denominator)
                begin
                    $error("bad_denominator: expected %0b, actual %0b",
                           want.bad_denominator, result.bad_denominator);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
